FILE: hdl/ded_pkg.sv
// Package: shared constants, register codes and cell control type for the embedding differencer.
`default_nettype none
package ded_pkg;

  // Window depth in differences; the window holds one more value
  localparam int MaxDim  = 32;
  localparam int SampleW = 64;
  localparam int DimW    = 6;
  localparam int WrapW   = 31;
  localparam int CfgIdxW = 8;
  localparam int CfgDataW = 32;

  // Effective dimension and emitted-result counter width (holds MaxDim itself)
  localparam int EffW  = $clog2(MaxDim + 1);
  // Warm-up counter width (holds MaxDim + 1)
  localparam int WarmW = $clog2(MaxDim + 2);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_DIMENSIONS   = 8'd0,
    REG_WRAP_MODULUS = 8'd1
  } cfg_reg_e;

  // Control broadcast to every cell
  typedef struct packed {
    logic load_diff;   // capture newer minus older from the window
    logic fix_diff;    // add wrap value to negative differences
    logic shift_diff;  // hand differences one cell up toward the tap
  } cell_ctrl_t;

endpackage : ded_pkg
`default_nettype wire

FILE: hdl/ded_cell.sv
// One window cell: holds a stored sample and the difference to its newer neighbor.
`default_nettype none
module ded_cell (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire ded_pkg::cell_ctrl_t              ctrl_i,
  input  wire logic                             win_en_i,
  input  wire logic [ded_pkg::WrapW-1:0]        wrap_i,
  input  wire logic [ded_pkg::SampleW-1:0]      prev_win_i,
  input  wire logic [ded_pkg::SampleW-1:0]      prev_diff_i,
  output logic      [ded_pkg::SampleW-1:0]      win_o,
  output logic      [ded_pkg::SampleW-1:0]      diff_o
);

  logic [ded_pkg::SampleW-1:0] win_q;
  logic [ded_pkg::SampleW-1:0] diff_q, diff_d;

  // Shift the stored sample in from the newer neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (win_en_i) begin
      win_q <= prev_win_i;
    end
  end

  // Load, wrap or pass along the difference
  always_comb begin
    diff_d = diff_q;
    if (ctrl_i.load_diff) begin
      diff_d = prev_win_i - win_q;
    end else if (ctrl_i.fix_diff) begin
      if (diff_q[ded_pkg::SampleW-1]) begin
        diff_d = diff_q + ded_pkg::SampleW'(wrap_i);
      end
    end else if (ctrl_i.shift_diff) begin
      diff_d = prev_diff_i;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
  end

  assign win_o  = win_q;
  assign diff_o = diff_q;

endmodule : ded_cell
`default_nettype wire

FILE: hdl/delay_embedding_differences_top.sv
// Top level: control, configuration registers and the row of window cells.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   input   | in        | in_valid_i/in_stall_o | sample_i (64b signed)
//   output  | out       | out_valid_o/out_stall_i | difference_o, last_of_row_o
//   config  | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// For an input that yields a row of d results, the accept cycle shifts the window,
// the LOAD state loads all differences, the FIX state wraps them, then one result
// per cycle, while out_stall_i is low, leaves the fixed tap at cell d - 1 as the
// differences move up the row. An input without results only shifts the window.
// Reset clears the window, warm-up count and wrap and sets the dimension to 3 at once; no clearing pass.
// A stalled result holds the row; no new input is taken until the row is out.
`default_nettype none
module delay_embedding_differences_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [ded_pkg::SampleW-1:0] sample_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [ded_pkg::SampleW-1:0]     difference_o,
  output logic                                   last_of_row_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [ded_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [ded_pkg::CfgDataW-1:0]      cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_FIX  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  localparam int CmpW = ded_pkg::EffW + ded_pkg::DimW + ded_pkg::WarmW;

  state_e                       state_q, state_d;
  logic [ded_pkg::DimW-1:0]     dim_q;
  logic [ded_pkg::WrapW-1:0]    wrap_q;
  logic [ded_pkg::WarmW-1:0]    warm_q, warm_d;
  logic [ded_pkg::EffW-1:0]     cnt_q, cnt_d;
  logic [ded_pkg::SampleW-1:0]  slot0_q;
  logic [ded_pkg::EffW-1:0]     eff_dim;
  logic                         in_acc, out_acc, emit_row, last_res;
  logic [ded_pkg::EffW-1:0]     tap_idx;
  ded_pkg::cell_ctrl_t          cell_ctrl;

  logic [ded_pkg::SampleW-1:0]  win_chain  [ded_pkg::MaxDim+1];
  logic [ded_pkg::SampleW-1:0]  diff_chain [ded_pkg::MaxDim+1];

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Saturate the dimension at the row length
  assign eff_dim = (CmpW'(dim_q) > CmpW'(ded_pkg::MaxDim)) ?
                   ded_pkg::EffW'(ded_pkg::MaxDim) : ded_pkg::EffW'(dim_q);

  // Configuration writes; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q  <= ded_pkg::DimW'(3);
      wrap_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ded_pkg::REG_DIMENSIONS:   dim_q  <= cfg_data_i[ded_pkg::DimW-1:0];
        ded_pkg::REG_WRAP_MODULUS: wrap_q <= cfg_data_i[ded_pkg::WrapW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the warm-up count, saturating one past the row length
  always_comb begin
    warm_d = warm_q;
    if (warm_q != ded_pkg::WarmW'(ded_pkg::MaxDim + 1)) begin
      warm_d = warm_q + ded_pkg::WarmW'(1);
    end
  end

  // A zero dimension only stores the sample; no row follows
  assign emit_row = (eff_dim != '0) && (CmpW'(warm_d) > CmpW'(eff_dim));
  assign last_res = (cnt_q == eff_dim);

  // Sequencer: shift, load, wrap, then drain the row
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cell_ctrl = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && emit_row) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cell_ctrl.load_diff = 1'b1;
        state_d = ST_FIX;
      end
      ST_FIX: begin
        cell_ctrl.fix_diff = 1'b1;
        cnt_d   = ded_pkg::EffW'(1);
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (last_res) begin
            state_d = ST_IDLE;
          end else begin
            cell_ctrl.shift_diff = 1'b1;
            cnt_d = cnt_q + ded_pkg::EffW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      warm_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (in_acc) begin
        warm_q <= warm_d;
      end
    end
  end

  // Newest slot takes every accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot0_q <= '0;
    end else if (in_acc) begin
      slot0_q <= sample_i;
    end
  end

  assign win_chain[0]  = slot0_q;
  assign diff_chain[0] = '0;

  // Row of cells; cell k holds window position k + 1
  for (genvar k = 0; k < ded_pkg::MaxDim; k++) begin : g_cell
    logic win_en;
    assign win_en = in_acc && (ded_pkg::EffW'(k) < eff_dim);

    ded_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .win_en_i    (win_en),
      .wrap_i      (wrap_q),
      .prev_win_i  (win_chain[k]),
      .prev_diff_i (diff_chain[k]),
      .win_o       (win_chain[k+1]),
      .diff_o      (diff_chain[k+1])
    );
  end

  // Read the row at the tap of the oldest difference
  assign tap_idx       = eff_dim;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = (state_q == ST_EMIT);
  assign difference_o  = diff_chain[tap_idx];
  assign last_of_row_o = last_res;

endmodule : delay_embedding_differences_top
`default_nettype wire

FILE: hdl/ded_checker.sv
// Checker: port-level properties of the embedding differencer, bound to the top level.
`default_nettype none
module ded_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [ded_pkg::SampleW-1:0]   difference_o,
  input wire logic                          last_of_row_o
);

  // No result leaves in the cycle right after a transaction is taken in
  a_no_result_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result presented right after input transaction");

  // Input is held off while a row drains
  a_stall_while_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while results pending");

  // A row continues without gaps until its last result
  a_row_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_of_row_o) |=> out_valid_o)
    else $error("gap inside a row of results");

  // The row ends after the last result is taken
  a_row_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_of_row_o) |=> !out_valid_o)
    else $error("result after end of row");

  // Hold a stalled result
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(difference_o) && $stable(last_of_row_o)))
    else $error("stalled result changed");

endmodule : ded_checker

bind delay_embedding_differences_top ded_checker u_ded_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .difference_o  (difference_o),
  .last_of_row_o (last_of_row_o)
);
`default_nettype wire

FILE: sim/delay_embedding_differences_top_tb.sv
`timescale 1ns / 1ps
// Testbench for the embedding differencer: directed and random samples, scoreboard check.
module delay_embedding_differences_top_tb;

  localparam logic [ded_pkg::CfgIdxW-1:0] CfgIdxFirstUnmapped = 8'd2;
  localparam logic [ded_pkg::CfgIdxW-1:0] CfgIdxLastUnmapped  = {ded_pkg::CfgIdxW{1'b1}};
  localparam logic [ded_pkg::SampleW-1:0] SampleMaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ded_pkg::SampleW-1:0] SampleMinNeg = 64'h8000_0000_0000_0000;
  localparam logic [ded_pkg::WrapW-1:0]   WrapMax      = {ded_pkg::WrapW{1'b1}};
  localparam int SettleCycles  = ded_pkg::MaxDim + 8;
  localparam int LongHold      = 150;
  localparam int DrainLimit    = 20000;
  localparam int ReportLimit   = 10;

  typedef struct packed {
    logic [ded_pkg::SampleW-1:0] difference;
    logic                        last_of_row;
  } diff_result_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic signed [ded_pkg::SampleW-1:0]  sample_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic signed [ded_pkg::SampleW-1:0]  difference_o;
  logic                                last_of_row_o;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [ded_pkg::CfgIdxW-1:0]         cfg_index_i;
  logic [ded_pkg::CfgDataW-1:0]        cfg_data_i;

  // Mirror of the block state
  logic [ded_pkg::SampleW-1:0] window_hist [0:ded_pkg::MaxDim];
  int                          seen_count;
  logic [ded_pkg::DimW-1:0]    dim_cfg;
  logic [ded_pkg::WrapW-1:0]   wrap_cfg;

  diff_result_t                diff_expected [$];
  int                          fail_count;
  bit                          idle_on;
  bit                          long_hold_req;
  logic [ded_pkg::SampleW-1:0] last_sample;

  delay_embedding_differences_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .difference_o  (difference_o),
    .last_of_row_o (last_of_row_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Bound the run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= ReportLimit) begin
      $display("[%0t] %s", $time, msg);
    end
  endfunction

  // Shift the sample into the window and queue the row of differences it yields
  function automatic void predict_row(input logic [ded_pkg::SampleW-1:0] s);
    int i;
    int d;
    logic [ded_pkg::SampleW-1:0] delta;
    diff_result_t r;
    d = (int'(dim_cfg) > ded_pkg::MaxDim) ? ded_pkg::MaxDim : int'(dim_cfg);
    for (i = d; i > 0; i--) begin
      window_hist[i] = window_hist[i-1];
    end
    window_hist[0] = s;
    if (seen_count < ded_pkg::MaxDim + 1) seen_count++;
    if (seen_count > d) begin
      for (i = d; i > 0; i--) begin
        delta = window_hist[i-1] - window_hist[i];
        if (delta[ded_pkg::SampleW-1]) begin
          delta = delta + {{(ded_pkg::SampleW-ded_pkg::WrapW){1'b0}}, wrap_cfg};
        end
        r.difference  = delta;
        r.last_of_row = (i == 1);
        diff_expected.push_back(r);
      end
    end
  endfunction

  // Check each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    diff_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (diff_expected.size() == 0) begin
        note_failure($sformatf("unexpected result difference=%h last=%b",
                               difference_o, last_of_row_o));
      end else begin
        want = diff_expected.pop_front();
        if (difference_o !== want.difference || last_of_row_o !== want.last_of_row) begin
          note_failure($sformatf("result mismatch: expected difference=%h last=%b, got %h %b",
                                 want.difference, want.last_of_row,
                                 difference_o, last_of_row_o));
        end
      end
    end
  end

  // Drive receiver stall: random bursts, or one long hold on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        long_hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one sample and hold it until the transaction completes; valid stays high after
  task automatic send_sample(input logic [ded_pkg::SampleW-1:0] s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    predict_row(s);
    last_sample = s;
  endtask

  // Drop valid, wait for every expected result, then let a row in flight finish
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (diff_expected.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [ded_pkg::CfgIdxW-1:0] idx,
                                input logic [ded_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == ded_pkg::REG_DIMENSIONS) dim_cfg = data[ded_pkg::DimW-1:0];
    else if (idx == ded_pkg::REG_WRAP_MODULUS) wrap_cfg = data[ded_pkg::WrapW-1:0];
  endtask

  // Reprogram both registers on an idle block; add a write to an unmapped index
  task automatic configure(input logic [ded_pkg::CfgDataW-1:0] dim_word,
                           input logic [ded_pkg::CfgDataW-1:0] wrap_word);
    wait_drained();
    write_register(ded_pkg::REG_DIMENSIONS, dim_word);
    write_register(ded_pkg::REG_WRAP_MODULUS, wrap_word);
    write_register(ded_pkg::CfgIdxW'($urandom_range(CfgIdxFirstUnmapped, CfgIdxLastUnmapped)),
                   $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [ded_pkg::SampleW-1:0] rand_sample();
    logic [ded_pkg::SampleW-1:0] v;
    case ($urandom_range(0, 3))
      0: v = {$urandom, $urandom};
      1: v = ded_pkg::SampleW'(signed'(64'($urandom_range(0, 2000)) - 64'd1000));
      2: begin
        case ($urandom_range(0, 3))
          0: v = SampleMaxPos;
          1: v = SampleMinNeg;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = last_sample +
                   ded_pkg::SampleW'(signed'(64'($urandom_range(0, 64)) - 64'd32));
    endcase
    return v;
  endfunction

  // Overflowing differences with the reset settings
  task automatic test_extremes();
    send_sample(SampleMaxPos);
    send_sample(SampleMinNeg);
    send_sample('0);
    send_sample(SampleMaxPos);
    send_sample('1);
    send_sample(64'd1);
  endtask

  // Add the largest wrap to negative differences; bit 31 of the data is dropped
  task automatic test_wrap();
    configure(32'hFFFF_FFC2, 32'hFFFF_FFFF);
    send_sample(64'd100);
    send_sample(64'd50);
    send_sample(64'd10);
    send_sample(SampleMinNeg);
  endtask

  // Store samples with no differences out
  task automatic test_zero_dim();
    configure(32'h0000_0040, 32'h0000_0000);
    send_sample(64'hDEAD_BEEF_0000_0001);
    send_sample(64'h0123_4567_89AB_CDEF);
  endtask

  // Grow the dimension so stale and reset slots come back into use
  task automatic test_dim_growth();
    configure(32'd1, 32'd7);
    send_sample(64'd5);
    send_sample(64'd9);
    send_sample(64'd2);
    configure(32'd6, 32'd7);
    send_sample(64'd11);
    send_sample(64'hFFFF_FFFF_FFFF_FF00);
  endtask

  // Saturate the dimension above the window size; warm-up may still hold output
  task automatic test_saturated_dim();
    configure(32'd63, 32'd0);
    send_sample(SampleMaxPos);
    send_sample(SampleMinNeg);
    send_sample(64'd3);
  endtask

  task automatic test_random_segment(input int n_items);
    logic [ded_pkg::CfgDataW-1:0] dim_word;
    logic [ded_pkg::CfgDataW-1:0] wrap_word;
    int k;
    dim_word  = $urandom;
    wrap_word = $urandom;
    case ($urandom_range(0, 9))
      0: dim_word[ded_pkg::DimW-1:0] = '0;
      1: dim_word[ded_pkg::DimW-1:0] = ded_pkg::DimW'(ded_pkg::MaxDim);
      2: dim_word[ded_pkg::DimW-1:0] = ded_pkg::DimW'($urandom_range(ded_pkg::MaxDim + 1, 63));
      default: dim_word[ded_pkg::DimW-1:0] = ded_pkg::DimW'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 3))
      0: wrap_word[ded_pkg::WrapW-1:0] = '0;
      1: wrap_word[ded_pkg::WrapW-1:0] = WrapMax;
      2: wrap_word[ded_pkg::WrapW-1:0] = ded_pkg::WrapW'($urandom_range(1, 1000));
      default: wrap_word[ded_pkg::WrapW-1:0] = ded_pkg::WrapW'($urandom);
    endcase
    configure(dim_word, wrap_word);
    for (k = 0; k < n_items; k++) begin
      send_sample(rand_sample());
    end
  endtask

  // Hold the output long enough that the input backs up
  task automatic test_output_hold();
    int k;
    configure(32'd4, 32'd1000);
    long_hold_req = 1'b1;
    for (k = 0; k < 8; k++) begin
      send_sample(rand_sample());
    end
  endtask

  // Pause the sender until every result is out, then resume
  task automatic test_sender_pause();
    int k;
    for (k = 0; k < 5; k++) send_sample(rand_sample());
    in_valid_i <= 1'b0;
    while (diff_expected.size() != 0) @(posedge clk_i);
    for (k = 0; k < 5; k++) send_sample(rand_sample());
  endtask

  // Back-to-back samples with no idling on either side
  task automatic test_steady_stream();
    int k;
    configure(32'd2, 32'd12345);
    idle_on = 1'b0;
    for (k = 0; k < 20; k++) send_sample(rand_sample());
  endtask

  initial begin
    int i;
    int waited;
    for (i = 0; i <= ded_pkg::MaxDim; i++) window_hist[i] = '0;
    seen_count    = 0;
    dim_cfg       = ded_pkg::DimW'(3);
    wrap_cfg      = '0;
    fail_count    = 0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    last_sample   = '0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    sample_i    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_wrap();
    test_zero_dim();
    test_dim_growth();
    test_saturated_dim();
    for (i = 0; i < 5; i++) test_random_segment(12);
    test_output_hold();
    test_sender_pause();
    test_steady_stream();

    // Drain with a bound, then flag anything still owed
    in_valid_i <= 1'b0;
    waited = 0;
    while (diff_expected.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (diff_expected.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", diff_expected.size()));
    end
    repeat (SettleCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
